@@ sv/awrtc_pkg.sv @@
// Shared types, constants and kernel helper functions of the resample tap combiner.
`timescale 1ns / 1ps

package awrtc_pkg;

   localparam int WFB       = 14;
   localparam int DIST_BITS = 12;
   localparam int DIST_ONE  = 1 << DIST_BITS;
   localparam int POLY_FRAC = 36;
   localparam int HALF_SH   = POLY_FRAC - WFB - 1;
   localparam int NUM_W     = 48;
   localparam int PREP_W    = 50;
   localparam int DIV_W     = 48;
   localparam int W_W       = 16;
   localparam int U_W       = 15;
   localparam int SQ_W      = 28;
   localparam int CU_W      = 43;

   localparam logic [2:0] KIND_BOX      = 3'd0;
   localparam logic [2:0] KIND_TRIANGLE = 3'd1;
   localparam logic [2:0] KIND_HERMITE  = 3'd2;
   localparam logic [2:0] KIND_QUAD     = 3'd3;
   localparam logic [2:0] KIND_CUBIC    = 3'd4;
   localparam logic [2:0] KIND_CATROM   = 3'd5;
   localparam logic [2:0] KIND_MITCHELL = 3'd6;
   // The remaining code selects no kernel and gives zero weight.
   localparam logic [2:0] KIND_NONE     = 3'd7;

   // Polynomial piece selected for one tap.
   localparam logic [3:0] P_ZERO  = 4'd0;
   localparam logic [3:0] P_BOX   = 4'd1;
   localparam logic [3:0] P_TRI   = 4'd2;
   localparam logic [3:0] P_HERM  = 4'd3;
   localparam logic [3:0] P_QIN   = 4'd4;
   localparam logic [3:0] P_QOUT  = 4'd5;
   localparam logic [3:0] P_CIN   = 4'd6;
   localparam logic [3:0] P_COUT  = 4'd7;
   localparam logic [3:0] P_CRIN  = 4'd8;
   localparam logic [3:0] P_CROUT = 4'd9;
   localparam logic [3:0] P_MIN   = 4'd10;
   localparam logic [3:0] P_MOUT  = 4'd11;

   localparam logic [1:0] DV_ONE   = 2'd0;
   localparam logic [1:0] DV_THREE = 2'd1;
   localparam logic [1:0] DV_NINE  = 2'd2;

   localparam logic [1:0] JOB_RED     = 2'd0;
   localparam logic [1:0] JOB_GREEN   = 2'd1;
   localparam logic [1:0] JOB_BLUE    = 2'd2;
   localparam logic [1:0] JOB_OPACITY = 2'd3;

   typedef struct packed {
      logic       load;
      logic       sq;
      logic       cu;
      logic       poly;
      logic       scale;
      logic       recip;
      logic       tw;
      logic       acc;
      logic       fload;
      logic       fstep;
      logic       fstore;
      logic       emit;
      logic [1:0] job;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic div_done;
      logic out_free;
   } status_type;

   function automatic logic [16:0] abs_dist(logic signed [15:0] x);
      logic signed [16:0] xs;
      xs = {x[15], x};
      return xs[16] ? 17'(-xs) : 17'(xs);
   endfunction

   function automatic logic [3:0] piece_of(logic [2:0] kind, logic signed [15:0] x);
      logic [16:0] a;
      logic [3:0]  p;
      a = abs_dist(x);
      p = P_ZERO;
      unique case (kind)
         KIND_BOX: begin
            if (int'(x) >= -(DIST_ONE / 2) && int'(x) < DIST_ONE / 2) p = P_BOX;
         end
         KIND_TRIANGLE: begin
            if (a < 17'(DIST_ONE)) p = P_TRI;
         end
         KIND_HERMITE: begin
            if (a < 17'(DIST_ONE)) p = P_HERM;
         end
         KIND_QUAD: begin
            if (a < 17'(DIST_ONE / 2)) p = P_QIN;
            else if (a < 17'(3 * DIST_ONE / 2)) p = P_QOUT;
         end
         KIND_CUBIC: begin
            if (a < 17'(DIST_ONE)) p = P_CIN;
            else if (a < 17'(2 * DIST_ONE)) p = P_COUT;
         end
         KIND_CATROM: begin
            if (a < 17'(DIST_ONE)) p = P_CRIN;
            else if (a < 17'(2 * DIST_ONE)) p = P_CROUT;
         end
         KIND_MITCHELL: begin
            if (a < 17'(DIST_ONE)) p = P_MIN;
            else if (a < 17'(2 * DIST_ONE)) p = P_MOUT;
         end
         default: p = P_ZERO;
      endcase
      return p;
   endfunction

   // Base value fed to the square and cube multipliers for a piece.
   function automatic logic signed [U_W-1:0] u_of(logic [3:0] piece, logic signed [15:0] x);
      logic [16:0]        a;
      logic signed [18:0] t;
      a = abs_dist(x);
      unique case (piece)
         P_ZERO, P_BOX: t = '0;
         P_QOUT:        t = $signed({1'b0, a, 1'b0}) - $signed(19'(3 * DIST_ONE));
         P_COUT:        t = $signed(19'(2 * DIST_ONE)) - $signed({2'b00, a});
         default:       t = $signed({2'b00, a});
      endcase
      return U_W'(t);
   endfunction

endpackage

@@ sv/awrtc_div.sv @@
// Iterative divider giving a quotient clamped to 0..255, one bit per stepped cycle.
`timescale 1ns / 1ps

module awrtc_div (
   input  logic                           clock,
   input  logic                           load,
   input  logic                           step,
   input  logic [awrtc_pkg::DIV_W-1:0]    numer,
   input  logic [awrtc_pkg::DIV_W-1:0]    denom,
   input  logic                           zero,
   output logic [7:0]                     quot,
   output logic                           done
);
   import awrtc_pkg::*;

   logic [DIV_W-1:0] rem_ff;
   logic [DIV_W-1:0] dsh_ff;
   logic [7:0]       q_ff;
   logic [3:0]       cnt_ff;
   logic             sat_ff;
   logic             zero_ff;
   logic             ge;

   assign ge = rem_ff >= dsh_ff;

   // The first step only tests against 256 times the divisor for saturation.
   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff  <= numer;
         dsh_ff  <= {denom[DIV_W-9:0], 8'b0};
         q_ff    <= '0;
         cnt_ff  <= '0;
         sat_ff  <= 1'b0;
         zero_ff <= zero;
      end else if (step) begin
         if (cnt_ff == 4'd0) begin
            sat_ff <= ge;
         end else begin
            if (ge) rem_ff <= rem_ff - dsh_ff;
            q_ff <= {q_ff[6:0], ge};
         end
         dsh_ff <= dsh_ff >> 1;
         cnt_ff <= cnt_ff + 4'd1;
      end
   end

   assign done = cnt_ff == 4'd8;
   assign quot = zero_ff ? 8'd0 : (sat_ff ? 8'd255 : q_ff);

endmodule

@@ sv/awrtc_dp.sv @@
// Datapath: kernel evaluation, accumulators, final normalization and result register.
`timescale 1ns / 1ps

module awrtc_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  awrtc_pkg::cmd_type      cmd,
   output awrtc_pkg::status_type   status,
   input  logic [47:0]             req_tdata,
   input  logic                    req_tlast,
   input  logic                    csr_valid,
   input  logic                    csr_ready,
   input  logic [2:0]              csr_data,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [31:0]             rsp_tdata
);
   import awrtc_pkg::*;

   localparam logic signed [NUM_W-1:0] S3 = NUM_W'(64'd1 << (3 * DIST_BITS));
   localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;
   localparam logic [31:0] RECIP9 = 32'h38E3_8E39;

   logic [2:0]  kind_ff;
   logic [7:0]  r_ff, g_ff, b_ff, op_ff;
   logic        last_ff;
   logic [3:0]  piece_ff;
   logic signed [U_W-1:0]  u_ff;
   logic [SQ_W-1:0]        sq_ff;
   logic signed [CU_W-1:0] cu_ff;
   logic signed [NUM_W-1:0] num_ff, num_in;
   logic [31:0] m_ff;
   logic [1:0]  dv_ff;
   logic        neg_ff;
   logic signed [W_W-1:0] w_ff, w_in;
   logic signed [24:0] tw_ff, wo_ff;
   logic signed [23:0] ws_ff;
   logic signed [31:0] ts_ff;
   logic signed [43:0] rs_ff, gs_ff, bs_ff;
   logic signed [35:0] os_ff;
   logic [7:0]  res_ff [4];
   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff;

   logic signed [15:0] tap_dist;
   assign tap_dist = $signed(req_tdata[47:32]);

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_MITCHELL;
      end else if (csr_valid && csr_ready) begin
         kind_ff <= csr_data;
      end
   end

   // Kernel pipeline steps, one per controller command.
   logic signed [NUM_W-1:0] eu, esq, ecu, sqs, as2;
   logic [NUM_W-1:0] nabs;
   logic [NUM_W:0]   rsum;
   logic [4:0]       sh;
   logic [NUM_W:0]   half;
   logic [63:0]      prod;
   logic [14:0]      qmag;

   always_comb begin
      eu  = NUM_W'(u_ff);
      esq = NUM_W'($signed({1'b0, sq_ff}));
      ecu = NUM_W'(cu_ff);
      sqs = esq <<< DIST_BITS;
      as2 = eu <<< (2 * DIST_BITS);
      unique case (piece_ff)
         P_TRI:   num_in = S3 - as2;
         P_HERM:  num_in = 48'sd2 * ecu - 48'sd3 * sqs + S3;
         P_QIN:   num_in = 48'sd3 * S3 - 48'sd4 * sqs;
         P_QOUT:  num_in = sqs;
         P_CIN:   num_in = 48'sd4 * S3 - 48'sd6 * sqs + 48'sd3 * ecu;
         P_COUT:  num_in = ecu;
         P_CRIN:  num_in = 48'sd2 * S3 - 48'sd5 * sqs + 48'sd3 * ecu;
         P_CROUT: num_in = 48'sd4 * S3 - 48'sd8 * as2 + 48'sd5 * sqs - ecu;
         P_MIN:   num_in = 48'sd16 * S3 - 48'sd36 * sqs + 48'sd21 * ecu;
         P_MOUT:  num_in = 48'sd32 * S3 - 48'sd60 * as2 + 48'sd36 * sqs - 48'sd7 * ecu;
         default: num_in = '0;
      endcase
   end

   // Rounding half away from zero: add half the divisor to the magnitude, shift out
   // the power of two, then divide by three or nine through a reciprocal.
   logic [1:0] dv_sel;
   always_comb begin
      nabs = num_ff[NUM_W-1] ? NUM_W'(-num_ff) : NUM_W'(num_ff);
      unique case (piece_ff)
         P_CRIN, P_CROUT: begin
            half = (NUM_W+1)'(2) << HALF_SH;  sh = 5'(HALF_SH + 2); dv_sel = DV_ONE;
         end
         P_QIN: begin
            half = (NUM_W+1)'(4) << HALF_SH;  sh = 5'(HALF_SH + 3); dv_sel = DV_ONE;
         end
         P_QOUT: begin
            half = (NUM_W+1)'(8) << HALF_SH;  sh = 5'(HALF_SH + 4); dv_sel = DV_ONE;
         end
         P_CIN, P_COUT: begin
            half = (NUM_W+1)'(6) << HALF_SH;  sh = 5'(HALF_SH + 2); dv_sel = DV_THREE;
         end
         P_MIN, P_MOUT: begin
            half = (NUM_W+1)'(18) << HALF_SH; sh = 5'(HALF_SH + 2); dv_sel = DV_NINE;
         end
         default: begin
            half = (NUM_W+1)'(1) << HALF_SH;  sh = 5'(HALF_SH + 1); dv_sel = DV_ONE;
         end
      endcase
      rsum = {1'b0, nabs} + half;
   end

   always_comb begin
      unique case (dv_ff)
         DV_THREE: prod = {32'b0, m_ff} * {32'b0, RECIP3};
         DV_NINE:  prod = {32'b0, m_ff} * {32'b0, RECIP9};
         default:  prod = {32'b0, m_ff};
      endcase
      qmag = (dv_ff == DV_ONE) ? prod[14:0] : prod[47:33];
      unique case (piece_ff)
         P_BOX:   w_in = W_W'(1 << WFB);
         P_ZERO:  w_in = '0;
         default: w_in = neg_ff ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         r_ff     <= req_tdata[7:0];
         g_ff     <= req_tdata[15:8];
         b_ff     <= req_tdata[23:16];
         op_ff    <= req_tdata[31:24];
         last_ff  <= req_tlast;
         piece_ff <= piece_of(kind_ff, tap_dist);
         u_ff     <= u_of(piece_of(kind_ff, tap_dist), tap_dist);
      end
      if (cmd.sq)    sq_ff  <= SQ_W'(u_ff * u_ff);
      if (cmd.cu)    cu_ff  <= CU_W'($signed({1'b0, sq_ff}) * u_ff);
      if (cmd.poly)  num_ff <= num_in;
      if (cmd.scale) begin
         m_ff   <= 32'(rsum >> sh);
         dv_ff  <= dv_sel;
         neg_ff <= num_ff[NUM_W-1];
      end
      if (cmd.recip) w_ff <= w_in;
      if (cmd.tw) begin
         tw_ff <= w_ff * $signed({1'b0, 8'(8'd255 - op_ff)});
         wo_ff <= w_ff * $signed({1'b0, op_ff});
      end
   end

   // Accumulators wrap at their own widths.
   logic signed [33:0] rp, gp, bp;
   assign rp = tw_ff * $signed({1'b0, r_ff});
   assign gp = tw_ff * $signed({1'b0, g_ff});
   assign bp = tw_ff * $signed({1'b0, b_ff});

   always_ff @(posedge clock) begin
      if (reset || cmd.emit) begin
         ws_ff <= '0;
         ts_ff <= '0;
         rs_ff <= '0;
         gs_ff <= '0;
         bs_ff <= '0;
         os_ff <= '0;
      end else if (cmd.acc) begin
         ws_ff <= ws_ff + 24'(w_ff);
         ts_ff <= ts_ff + 32'(tw_ff);
         rs_ff <= rs_ff + 44'(rp);
         gs_ff <= gs_ff + 44'(gp);
         bs_ff <= bs_ff + 44'(bp);
         os_ff <= os_ff + 36'(wo_ff);
      end
   end

   // Operand preparation for one normalization job.
   logic signed [PREP_W-1:0] pn, pd, pn2, pd2, cden;
   logic [DIV_W-1:0] dnum, dden;
   logic             dzero;
   always_comb begin
      if (ts_ff != '0)      cden = PREP_W'(ts_ff);
      else if (ws_ff != '0) cden = (PREP_W'(ws_ff) <<< 8) - PREP_W'(ws_ff);
      else                  cden = PREP_W'(255) <<< WFB;
      unique case (cmd.job)
         JOB_RED:   begin pn = PREP_W'(rs_ff); pd = cden; end
         JOB_GREEN: begin pn = PREP_W'(gs_ff); pd = cden; end
         JOB_BLUE:  begin pn = PREP_W'(bs_ff); pd = cden; end
         default: begin
            pn = PREP_W'(os_ff);
            pd = (ws_ff != '0) ? PREP_W'(ws_ff) : (PREP_W'(1) <<< WFB);
         end
      endcase
      if (pd < 0) begin
         pn2 = -pn;
         pd2 = -pd;
      end else begin
         pn2 = pn;
         pd2 = pd;
      end
      dzero = pn2 <= 0;
      dnum  = DIV_W'((pn2 <<< 1) + pd2);
      dden  = DIV_W'(pd2 <<< 1);
   end

   logic [7:0] quot;
   logic       div_done;

   awrtc_div u_div (
      .clock (clock),
      .load  (cmd.fload),
      .step  (cmd.fstep),
      .numer (dnum),
      .denom (dden),
      .zero  (dzero),
      .quot  (quot),
      .done  (div_done)
   );

   always_ff @(posedge clock) begin
      if (cmd.fstore) res_ff[cmd.job] <= quot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) rsp_data_ff <= {res_ff[3], res_ff[2], res_ff[1], res_ff[0]};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign status.last     = last_ff;
   assign status.div_done = div_done;
   assign status.out_free = !rsp_valid_ff || rsp_tready;

endmodule

@@ sv/awrtc_ctrl.sv @@
// Controller state machine sequencing the kernel, accumulate and normalize steps.
`timescale 1ns / 1ps

module awrtc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  awrtc_pkg::status_type   status,
   output awrtc_pkg::cmd_type      cmd
);
   import awrtc_pkg::*;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_SQ     = 4'd1;
   localparam logic [3:0] ST_CU     = 4'd2;
   localparam logic [3:0] ST_POLY   = 4'd3;
   localparam logic [3:0] ST_SCALE  = 4'd4;
   localparam logic [3:0] ST_RECIP  = 4'd5;
   localparam logic [3:0] ST_TW     = 4'd6;
   localparam logic [3:0] ST_ACC    = 4'd7;
   localparam logic [3:0] ST_FLOAD  = 4'd8;
   localparam logic [3:0] ST_FRUN   = 4'd9;
   localparam logic [3:0] ST_FSTORE = 4'd10;
   localparam logic [3:0] ST_EMIT   = 4'd11;

   logic [3:0] state_ff, state_in;
   logic [1:0] job_ff, job_in;

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      cmd      = '0;
      cmd.job  = job_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = req_tvalid;
            if (req_tvalid) state_in = ST_SQ;
         end
         ST_SQ:    begin cmd.sq    = 1'b1; state_in = ST_CU;    end
         ST_CU:    begin cmd.cu    = 1'b1; state_in = ST_POLY;  end
         ST_POLY:  begin cmd.poly  = 1'b1; state_in = ST_SCALE; end
         ST_SCALE: begin cmd.scale = 1'b1; state_in = ST_RECIP; end
         ST_RECIP: begin cmd.recip = 1'b1; state_in = ST_TW;    end
         ST_TW:    begin cmd.tw    = 1'b1; state_in = ST_ACC;   end
         ST_ACC: begin
            cmd.acc = 1'b1;
            job_in  = JOB_RED;
            state_in = status.last ? ST_FLOAD : ST_IDLE;
         end
         ST_FLOAD: begin cmd.fload = 1'b1; state_in = ST_FRUN; end
         ST_FRUN: begin
            cmd.fstep = 1'b1;
            if (status.div_done) state_in = ST_FSTORE;
         end
         ST_FSTORE: begin
            cmd.fstore = 1'b1;
            if (job_ff == JOB_OPACITY) begin
               state_in = ST_EMIT;
            end else begin
               job_in   = job_ff + 2'd1;
               state_in = ST_FLOAD;
            end
         end
         ST_EMIT: begin
            cmd.emit = status.out_free;
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         job_ff   <= JOB_RED;
      end else begin
         state_ff <= state_in;
         job_ff   <= job_in;
      end
   end

   assign req_tready = state_ff == ST_IDLE;

endmodule

@@ sv/alpha_weighted_resample_tap_combiner_unit.sv @@
// Top level of the transparency-weighted resample tap combiner.
//
//  channel  direction  handshake                 contents
//  req      in         req_tvalid / req_tready   one tap word, req_tlast closes the pixel
//  rsp      out        rsp_tvalid / rsp_tready   one resampled ARGB pixel
//  csr      in         csr_valid / csr_ready     kernel kind, 3 bits
//
// A tap is accepted, then goes through square, cube, polynomial, scale, reciprocal,
// weight product and accumulate, each through registered stages. A last tap then
// runs four normalizations on one bit-serial divider and loads the result register
// once that register is free.
// The result register lets the next tap enter while a pixel waits on rsp_tready.
// Reset is synchronous and clears the accumulators and sets the kernel to Mitchell.
`timescale 1ns / 1ps

module alpha_weighted_resample_tap_combiner_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tap_red, tap_green, tap_blue, tap_opacity, tap_distance
   input  logic [47:0] req_tdata,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_red, out_green, out_blue, out_opacity
   output logic [31:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_data
);
   import awrtc_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   awrtc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   awrtc_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ sv/awrtc_chk.sv @@
// Port-level checker for the resample tap combiner, bound to the top level.
`timescale 1ns / 1ps

module awrtc_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // A waiting pixel is held until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed or dropped while stalled");

   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Each tap is worked on alone, so the input closes right after a word is taken.
   a_one_tap: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second tap accepted while one is in work");

   // Normalization takes many cycles, so no pixel appears right after a tap.
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result appeared one cycle after a tap");

endmodule

bind alpha_weighted_resample_tap_combiner_unit awrtc_chk u_awrtc_chk (.*);

@@ verif/tb_top.sv @@
// Self-checking testbench of the transparency-weighted resample tap combiner.
`timescale 1ns / 1ps

class pixel_scoreboard;
   bit [2:0]         kind;
   longint           wsum, tsum, rsum, gsum, bsum, osum;
   bit [31:0]        pending[$];
   int               errors;

   function new();
      kind = awrtc_pkg::KIND_MITCHELL;
      errors = 0;
      clear();
   endfunction

   function void clear();
      wsum = 0; tsum = 0; rsum = 0; gsum = 0; bsum = 0; osum = 0;
   endfunction

   function longint wrap(longint v, int bits);
      longint m;
      m = v << (64 - bits);
      return m >>> (64 - bits);
   endfunction

   function longint rdiv(longint n, longint d);
      if (n >= 0) return (n + d / 2) / d;
      return -((-n + d / 2) / d);
   endfunction

   function longint weight_of(bit [2:0] k, longint x);
      longint s, s2, s3, a, a2, a3, num, den, t;
      s = 4096; s2 = s * s; s3 = s2 * s;
      a = x < 0 ? -x : x; a2 = a * a; a3 = a2 * a;
      den = 1;
      case (k)
         awrtc_pkg::KIND_BOX: begin
            return (x >= -(s / 2) && x < s / 2) ? (64'sd1 << 14) : 0;
         end
         awrtc_pkg::KIND_TRIANGLE: begin
            if (a >= s) return 0;
            num = (s - a) * s2;
         end
         awrtc_pkg::KIND_HERMITE: begin
            if (a >= s) return 0;
            num = 2 * a3 - 3 * a2 * s + s3;
         end
         awrtc_pkg::KIND_QUAD: begin
            if (a < s / 2) begin
               num = 3 * s3 - 4 * a2 * s; den = 4;
            end else if (2 * a < 3 * s) begin
               t = 2 * a - 3 * s; num = t * t * s; den = 8;
            end else return 0;
         end
         awrtc_pkg::KIND_CUBIC: begin
            if (a < s) num = 4 * s3 - 6 * a2 * s + 3 * a3;
            else if (a < 2 * s) begin
               t = 2 * s - a; num = t * t * t;
            end else return 0;
            den = 6;
         end
         awrtc_pkg::KIND_CATROM: begin
            if (a < s) num = 2 * s3 - 5 * a2 * s + 3 * a3;
            else if (a < 2 * s) num = 4 * s3 - 8 * a * s2 + 5 * a2 * s - a3;
            else return 0;
            den = 2;
         end
         awrtc_pkg::KIND_MITCHELL: begin
            if (a < s) num = 16 * s3 - 36 * a2 * s + 21 * a3;
            else if (a < 2 * s) num = 32 * s3 - 60 * a * s2 + 36 * a2 * s - 7 * a3;
            else return 0;
            den = 18;
         end
         default: return 0;
      endcase
      return rdiv(num, den << 22);
   endfunction

   function bit [7:0] quantize(longint num, longint den);
      longint q;
      if (den < 0) begin
         num = -num; den = -den;
      end
      if (num <= 0) return 0;
      q = (2 * num + den) / (2 * den);
      return q > 255 ? 8'd255 : 8'(q);
   endfunction

   function bit [7:0] colour(longint sum);
      if (tsum != 0) return quantize(sum, tsum);
      if (wsum != 0) return quantize(sum, 255 * wsum);
      return quantize(sum, 64'sd255 << 14);
   endfunction

   function void note_tap(bit [47:0] d, bit last);
      longint w, tw, op;
      w = weight_of(kind, longint'($signed(d[47:32])));
      op = d[31:24];
      tw = w * (255 - op);
      wsum = wrap(wsum + w, 24);
      tsum = wrap(tsum + tw, 32);
      rsum = wrap(rsum + tw * d[7:0], 44);
      gsum = wrap(gsum + tw * d[15:8], 44);
      bsum = wrap(bsum + tw * d[23:16], 44);
      osum = wrap(osum + w * op, 36);
      if (last) begin
         pending.push_back({wsum != 0 ? quantize(osum, wsum) : quantize(osum, 64'sd1 << 14),
                            colour(bsum), colour(gsum), colour(rsum)});
         clear();
      end
   endfunction

   function void check_pixel(bit [31:0] got);
      bit [31:0] exp_px;
      if (pending.size() == 0) begin
         $display("%0t: unexpected pixel %h", $time, got);
         errors++;
         return;
      end
      exp_px = pending.pop_front();
      for (int i = 0; i < 4; i++)
         if (exp_px[8*i +: 8] !== got[8*i +: 8]) begin
            $display("%0t: channel %0d expected %0d actual %0d", $time, i,
                     exp_px[8*i +: 8], got[8*i +: 8]);
            errors++;
         end
   endfunction
endclass

module tb_top;
   import awrtc_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0, req_tlast = 0, rsp_tready = 0, csr_valid = 0;
   logic [47:0] req_tdata = '0;
   logic [2:0]  csr_data = '0;
   logic        req_tready, rsp_tvalid, csr_ready;
   logic [31:0] rsp_tdata;
   int          idle_cycles = 0;
   bit          stall_mode = 0;
   pixel_scoreboard sb = new();

   always #1 clock = ~clock;

   alpha_weighted_resample_tap_combiner_unit dut (.*);

   // Receiver stalls in phases: sometimes always ready, sometimes randomly ready.
   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
      rsp_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
      if (!reset && rsp_tvalid && rsp_tready) sb.check_pixel(rsp_tdata);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) || reset)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   task automatic send_tap(bit [7:0] r, g, b, op, bit [15:0] tap_dist, bit last);
      req_tvalid <= 1;
      req_tdata <= {tap_dist, op, b, g, r};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_tap({tap_dist, op, b, g, r}, last);
   endtask

   task automatic gap();
      if ($urandom_range(0, 3) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 0;
      req_tlast <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic set_kind(bit [2:0] k);
      csr_valid <= 1;
      csr_data <= k;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      sb.kind = k;
   endtask

   function automatic bit [15:0] pick_dist();
      case ($urandom_range(0, 5))
         0: return 16'($urandom);
         1: return {$urandom_range(0, 1) ? 4'hF : 4'h0, 12'($urandom)};
         default: return 16'($signed($urandom_range(0, 18000)) - 9000);
      endcase
   endfunction

   task automatic random_pixel();
      int n;
      n = $urandom_range(0, 9) == 0 ? $urandom_range(17, 20) : $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
         send_tap(8'($urandom), 8'($urandom), 8'($urandom),
                  $urandom_range(0, 4) == 0 ? ($urandom_range(0, 1) ? 8'd255 : 8'd0) : 8'($urandom),
                  pick_dist(), i == n - 1);
         gap();
      end
   endtask

   initial begin
      bit [15:0] edges[8];
      edges = '{16'h0000, 16'hF800, 16'h07FF, 16'h0800, 16'h1000, 16'hF000,
                16'h7FFF, 16'h8000};
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Extremes of each field with the reset kernel.
      send_tap(8'd255, 8'd0, 8'd255, 8'd0, 16'h0000, 0);
      send_tap(8'd0, 8'd255, 8'd0, 8'd255, 16'h1000, 1);
      send_tap(8'd10, 8'd20, 8'd30, 8'd255, 16'h0000, 1);   // fully transparent pixel
      send_tap(8'd10, 8'd20, 8'd30, 8'd0, 16'h7FFF, 1);     // outside support, zero weight
      send_tap(8'd200, 8'd100, 8'd50, 8'd0, 16'h1800, 1);   // negative lobe only
      drain();
      for (int k = 0; k < 8; k++) begin
         set_kind(3'(k));
         for (int e = 0; e < 8; e++)
            send_tap(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     edges[e], e[0]);
         drain();
      end
      for (int ph = 0; ph < 10; ph++) begin
         set_kind(ph == 0 ? KIND_BOX : ph == 1 ? KIND_NONE : 3'($urandom_range(0, 7)));
         for (int p = 0; p < 33; p++) random_pixel();
         drain();
      end
      if (sb.errors == 0) $display("tb_top: PASS");
      else $display("tb_top: FAIL");
      $finish;
   end
endmodule
